// ===== src/fre_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fre_pkg: shared constants and types for the frame rate estimator
// Ring geometry, field widths, register indexes and the divider request.
// ----------------------------------------------------------------------------
package fre_pkg;

    localparam int WINDOW   = 8;                      // ring entries, 3..64
    localparam int AW       = $clog2(WINDOW);         // ring address width
    localparam int CW       = $clog2(WINDOW + 1);     // count of entries 0..WINDOW
    localparam int FACTOR_W = 8;
    localparam int RATE_W   = 8;
    localparam int SUM_W    = FACTOR_W + CW;          // holds sum + count/2
    localparam int DIV_W    = SUM_W;                  // divider dividend width
    localparam int DVS_W    = FACTOR_W;               // divider divisor width
    localparam int CMP_W    = 8;                      // width for count compare

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int MIN_W      = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_LEGACY_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_RATE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES = 2'd2;

    localparam logic [RATE_W-1:0] FULL_RATE_RESET   = 8'd60;
    localparam logic [MIN_W-1:0]  MIN_SAMPLES_RESET = 4'd4;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

endpackage

// ===== src/frame_rate_estimator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_rate_estimator: windowed rounded-mean frame rate estimator
// Stores frame pacing factors in a ring memory and answers each one with
// a rate estimate and the factor used to form it.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one word per frame: the pacing factor. m_* channel
//   returns one word per input: rate and the factor used (both 0 if unknown).
//   cfg_* channel writes legacy_mode (0), full_rate (1), min_samples (2);
//   other indexes are ignored. Write only while the block is idle.
//   One item is in flight at a time. Each item writes its factor into the
//   ring, then a sweep reads all WINDOW entries (one read a cycle, with a
//   registered read), then a shared restoring divider runs at most once
//   (legacy rule) or twice (mean rule). The sweep and the divider set the
//   time taken per item.
//   A finished word waits in the output register; the next item is accepted
//   meanwhile and its result is held back until m_tready takes the old word.
//   Reset clears the ring (per-entry valid bits), the cursor and the
//   registers to legacy_mode 0, full_rate 60, min_samples 4.
// ----------------------------------------------------------------------------
module frame_rate_estimator
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,    // [7:0] factor
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [15:0]                      m_tdata,    // [7:0] rate, [15:8] mean_factor
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fre_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fre_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import fre_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SWEEP = 3'd1;
    localparam logic [2:0] ST_CALC  = 3'd2;
    localparam logic [2:0] ST_DIV1  = 3'd3;
    localparam logic [2:0] ST_DIV2  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    // configuration
    logic                legacy_mode_reg;
    logic [RATE_W-1:0]   full_rate_reg;
    logic [MIN_W-1:0]    min_samples_reg;

    // ring memory
    logic [FACTOR_W-1:0] ring_mem [WINDOW];
    logic [WINDOW-1:0]   ring_vld_reg;
    logic [FACTOR_W-1:0] rd_data_reg;
    logic                rd_vld_reg;
    logic [AW-1:0]       rd_addr_q_reg;
    logic                rd_pend_reg;

    // control
    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [AW-1:0]       cursor_reg;
    logic [AW-1:0]       cur_next;
    logic [AW-1:0]       idx_b_next;
    logic [AW-1:0]       idx_c_next;
    logic [AW-1:0]       idx_a_reg;
    logic [AW-1:0]       idx_b_reg;
    logic [AW-1:0]       idx_c_reg;
    logic [CW-1:0]       swp_cnt_reg;

    // datapath
    logic [SUM_W-1:0]    sum_reg;
    logic [CW-1:0]       cnt_reg;
    logic [FACTOR_W-1:0] a_reg;
    logic [FACTOR_W-1:0] b_reg;
    logic [FACTOR_W-1:0] c_reg;
    logic [FACTOR_W-1:0] used_reg;
    logic [RATE_W-1:0]   rate_reg;
    logic                m_tvalid_reg;
    logic [15:0]         m_tdata_reg;

    logic                in_acc;
    logic                issuing;
    logic [FACTOR_W-1:0] entry;
    logic                out_free;
    logic                legacy_hit;
    logic                mean_ok;
    div_req_t            div_req;
    logic                div_done;
    logic [DIV_W-1:0]    div_q;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign issuing   = (state_reg == ST_SWEEP) && (swp_cnt_reg != CW'(WINDOW));
    assign entry     = rd_vld_reg ? rd_data_reg : '0;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign cur_next   = (cursor_reg == AW'(WINDOW - 1)) ? '0 : cursor_reg + 1'b1;
    assign idx_b_next = (cur_next == '0) ? AW'(WINDOW - 1) : cur_next - 1'b1;
    assign idx_c_next = (idx_b_next == '0) ? AW'(WINDOW - 1) : idx_b_next - 1'b1;

    assign legacy_hit = (a_reg != '0) && (a_reg == b_reg) && (a_reg == c_reg);
    assign mean_ok    = (cnt_reg != '0) && (CMP_W'(cnt_reg) >= CMP_W'(min_samples_reg));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            legacy_mode_reg <= 1'b0;
            full_rate_reg   <= FULL_RATE_RESET;
            min_samples_reg <= MIN_SAMPLES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LEGACY_MODE: legacy_mode_reg <= cfg_data[0];
                CFG_FULL_RATE:   full_rate_reg   <= cfg_data[RATE_W-1:0];
                CFG_MIN_SAMPLES: min_samples_reg <= cfg_data[MIN_W-1:0];
                default:         ;
            endcase
        end
    end

    // ring memory: write on accept, read during the sweep
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ring_mem[cur_next] <= s_tdata;
        end
        rd_data_reg   <= ring_mem[swp_cnt_reg[AW-1:0]];
        rd_addr_q_reg <= swp_cnt_reg[AW-1:0];
    end

    // unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_vld_reg <= '0;
            rd_vld_reg   <= 1'b0;
            rd_pend_reg  <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                ring_vld_reg[cur_next] <= 1'b1;
            end
            rd_vld_reg  <= ring_vld_reg[swp_cnt_reg[AW-1:0]];
            rd_pend_reg <= issuing;
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        div_req      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                // last read word is folded in during this cycle
                if (!issuing)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (legacy_mode_reg)
                begin
                    if (legacy_hit)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DIV_W'(full_rate_reg);
                        div_req.divisor  = a_reg;
                        state_next       = ST_DIV2;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (mean_ok)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = sum_reg + SUM_W'(cnt_reg >> 1);
                    div_req.divisor  = DVS_W'(cnt_reg);
                    state_next       = ST_DIV1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV1:
            begin
                if (div_done)
                begin
                    if (div_q[FACTOR_W-1:0] != '0)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DIV_W'(full_rate_reg);
                        div_req.divisor  = div_q[FACTOR_W-1:0];
                        state_next       = ST_DIV2;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DIV2:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cursor_reg   <= '0;
            swp_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc)
            begin
                cursor_reg  <= cur_next;
                swp_cnt_reg <= '0;
            end
            else if (issuing)
            begin
                swp_cnt_reg <= swp_cnt_reg + 1'b1;
            end

            if (state_reg == ST_DONE && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // accumulation and result capture
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            sum_reg   <= '0;
            cnt_reg   <= '0;
            idx_a_reg <= cur_next;
            idx_b_reg <= idx_b_next;
            idx_c_reg <= idx_c_next;
            used_reg  <= '0;
            rate_reg  <= '0;
        end
        else if (rd_pend_reg)
        begin
            if (entry != '0)
            begin
                sum_reg <= sum_reg + SUM_W'(entry);
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (rd_addr_q_reg == idx_a_reg)
            begin
                a_reg <= entry;
            end
            if (rd_addr_q_reg == idx_b_reg)
            begin
                b_reg <= entry;
            end
            if (rd_addr_q_reg == idx_c_reg)
            begin
                c_reg <= entry;
            end
        end

        if (state_reg == ST_CALC && legacy_mode_reg && legacy_hit)
        begin
            used_reg <= a_reg;
        end
        if (state_reg == ST_DIV1 && div_done)
        begin
            used_reg <= div_q[FACTOR_W-1:0];
        end
        if (state_reg == ST_DIV2 && div_done)
        begin
            rate_reg <= div_q[RATE_W-1:0];
        end

        if (state_reg == ST_DONE && out_free)
        begin
            m_tdata_reg <= {used_reg, rate_reg};
        end
    end

    fre_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== src/fre_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fre_div: restoring divider, one quotient bit per cycle
// Shared by the rounded-mean division and the rate division.
// ----------------------------------------------------------------------------
module fre_div
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  fre_pkg::div_req_t       req,
    output logic                    done,
    output logic [fre_pkg::DIV_W-1:0] quotient
);
    import fre_pkg::*;

    localparam int ITER_W = $clog2(DIV_W);

    logic [DIV_W-1:0]  dq_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [ITER_W-1:0] iter_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DVS_W:0]    shifted;
    logic [DVS_W:0]    diff;
    logic              ge;

    assign shifted = {rem_reg, dq_reg[DIV_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = (shifted >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && iter_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dq_reg   <= req.dividend;
            dvs_reg  <= req.divisor;
            rem_reg  <= '0;
            iter_reg <= ITER_W'(DIV_W - 1);
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            dq_reg   <= {dq_reg[DIV_W-2:0], ge};
            iter_reg <= iter_reg - 1'b1;
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule
